// File: hw/rtl/fsqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqs_pkg
// Shared types and constants of the four-sum quadruple search core.
// ----------------------------------------------------------------------------
package fsqs_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned OUT_W    = 4 * VALUE_W;
    localparam int unsigned USER_W   = 3;
    localparam int unsigned PADDR_W  = 3;

    // register index (paddr[2]) of target_sum
    localparam logic REG_TARGET = 1'b0;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic dropped;
        logic capped;
        logic found;
    } t_flags;

endpackage

// File: hw/rtl/fsqs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqs_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fsqs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hw/rtl/four_sum_quadruple_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_sum_quadruple_search_core
// Collects a set of signed values, sorts it and reports every distinct
// quadruple whose sum equals target_sum.
// ----------------------------------------------------------------------------
// Usage: values stream in on s_axis at one transfer per cycle; the transfer
// with tlast ends the set. s_axis_tready then drops while the block works.
// The stored set (n values, at most MAX_ITEMS; extra items are discarded and
// flagged as dropped) is insertion-sorted in place in a two-read-port RAM.
// The search then runs over the sorted set with one shared sum/compare unit,
// twice when something matches: a first pass counts matches (and detects the
// result limit, which sets capped on every result), a second pass emits them.
// Each pointer step is a RAM read then a compare. Results leave through an
// output register on m_axis, with tlast on the final one; when nothing
// matches, a single result with found=0 and zero values is given. The block
// returns to loading once the last result has been transferred. target_sum
// is written over APB at byte address 0 and must only be changed while the
// block is idle.
// ----------------------------------------------------------------------------
module four_sum_quadruple_search_core #(
    parameter int unsigned MAX_ITEMS   = 32,
    parameter int unsigned MAX_RESULTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream, tdata: value[31:0]; tlast: last_item
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fsqs_pkg::VALUE_W-1:0]   s_axis_tdata,
    input  logic                           s_axis_tlast,
    // master stream, tdata: first[31:0], second[63:32], third[95:64],
    // fourth[127:96]; tuser: found[0], capped[1], dropped[2];
    // tlast: last_result
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fsqs_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic [fsqs_pkg::USER_W-1:0]    m_axis_tuser,
    output logic                           m_axis_tlast,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fsqs_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    import fsqs_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned RW = $clog2(MAX_RESULTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
    localparam logic [RW-1:0] RES_MAX = RW'(MAX_RESULTS);

    typedef enum logic [4:0] {
        ST_LOAD, ST_SORT_RD, ST_SORT_GET, ST_SORT_CHK, ST_SORT_CMP, ST_SORT_PUT,
        ST_INIT, ST_I_TOP, ST_I_GET, ST_J_TOP, ST_J_GET, ST_P_TOP, ST_P_EVAL,
        ST_D_LO, ST_D_LO_CHK, ST_D_HI, ST_D_HI_CHK, ST_J_SKIP, ST_J_SKIP_CHK,
        ST_I_SKIP, ST_I_SKIP_CHK, ST_END, ST_OUT_WAIT
    } t_state;

    t_state          r_state;
    t_value          r_target;
    logic [CW-1:0]   r_cnt;     // item_count
    logic            r_ovf;     // overflow_seen
    logic [CW-1:0]   r_i, r_j, r_lo, r_hi;
    t_value          r_v, r_ai, r_aj, r_q2, r_q3;
    logic [33:0]     r_need;
    logic            r_pass2;
    logic [RW-1:0]   r_count, r_total;
    logic            r_capped;
    logic            r_done;    // final result loaded

    logic            r_ovalid, r_olast;
    logic [OUT_W-1:0] r_odata;
    t_flags          r_oflags;

    // RAM ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_ra, ram_rb;
    t_value          ram_wdata, rd_a, rd_b;

    logic            in_xfer, out_xfer, cfg_wr;
    logic [33:0]     pair_sum;
    logic [CW-1:0]   i_next, j_next;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = r_ovalid && m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_TARGET);
    assign i_next   = r_i + CW'(1);
    assign j_next   = r_j + CW'(1);

    // shared sum: a[lo] + a[hi], sign-extended to the width of need
    assign pair_sum = {{2{rd_a[VALUE_W-1]}}, rd_a} + {{2{rd_b[VALUE_W-1]}}, rd_b};

    fsqs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_ra),
        .i_raddr_b (ram_rb),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // read address A picks the element that the next state loads or compares against
    always_comb begin
        case (r_state)
            ST_SORT_RD, ST_I_TOP: ram_ra = r_i[AW-1:0];
            ST_SORT_CHK:          ram_ra = AW'(r_j - CW'(1));
            ST_J_TOP:             ram_ra = r_j[AW-1:0];
            ST_J_SKIP:            ram_ra = AW'(j_next);
            ST_I_SKIP:            ram_ra = AW'(i_next);
            default:              ram_ra = r_lo[AW-1:0];
        endcase
    end
    assign ram_rb = r_hi[AW-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = r_v;
        case (r_state)
            ST_LOAD: begin
                ram_we    = in_xfer && (r_cnt < CNT_MAX);
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = t_value'(s_axis_tdata);
            end
            ST_SORT_CMP: begin
                ram_we    = $signed(rd_a) > $signed(r_v);
                ram_wdata = rd_a;
            end
            ST_SORT_PUT: ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_target <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_pass2  <= 1'b0;
            r_count  <= '0;
            r_total  <= '0;
            r_capped <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_target <= t_value'(pwdata);
            end
            if (out_xfer) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (in_xfer) begin
                        if (r_cnt < CNT_MAX) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_i     <= '0;
                            r_state <= ST_SORT_RD;
                        end
                    end
                end
                // ---- insertion sort in place ----
                ST_SORT_RD: begin
                    r_state <= (r_i >= r_cnt) ? ST_INIT : ST_SORT_GET;
                end
                ST_SORT_GET: begin
                    r_v     <= rd_a;
                    r_j     <= r_i;
                    r_state <= ST_SORT_CHK;
                end
                ST_SORT_CHK: begin
                    r_state <= (r_j == '0) ? ST_SORT_PUT : ST_SORT_CMP;
                end
                ST_SORT_CMP: begin
                    if ($signed(rd_a) > $signed(r_v)) begin
                        r_j     <= r_j - CW'(1);
                        r_state <= ST_SORT_CHK;
                    end else begin
                        r_state <= ST_SORT_PUT;
                    end
                end
                ST_SORT_PUT: begin
                    r_i     <= i_next;
                    r_state <= ST_SORT_RD;
                end
                // ---- search pass ----
                ST_INIT: begin
                    r_i     <= '0;
                    r_count <= '0;
                    r_state <= ST_I_TOP;
                end
                ST_I_TOP: begin
                    r_state <= (r_i >= r_cnt) ? ST_END : ST_I_GET;
                end
                ST_I_GET: begin
                    r_ai    <= rd_a;
                    r_j     <= i_next;
                    r_state <= ST_J_TOP;
                end
                ST_J_TOP: begin
                    r_state <= (r_j >= r_cnt) ? ST_I_SKIP : ST_J_GET;
                end
                ST_J_GET: begin
                    r_aj    <= rd_a;
                    r_need  <= {{2{r_target[VALUE_W-1]}}, r_target}
                             - ({{2{r_ai[VALUE_W-1]}}, r_ai}
                             +  {{2{rd_a[VALUE_W-1]}}, rd_a});
                    r_lo    <= j_next;
                    r_hi    <= r_cnt - CW'(1);
                    r_state <= ST_P_TOP;
                end
                ST_P_TOP: begin
                    r_state <= (r_lo < r_hi) ? ST_P_EVAL : ST_J_SKIP;
                end
                ST_P_EVAL: begin
                    if ($signed(pair_sum) < $signed(r_need)) begin
                        r_lo    <= r_lo + CW'(1);
                        r_state <= ST_P_TOP;
                    end else if ($signed(pair_sum) > $signed(r_need)) begin
                        r_hi    <= r_hi - CW'(1);
                        r_state <= ST_P_TOP;
                    end else begin
                        r_q2 <= rd_a;
                        r_q3 <= rd_b;
                        if (!r_pass2) begin
                            if (r_count >= RES_MAX) begin
                                // one more than the limit: stop counting
                                r_capped <= 1'b1;
                                r_state  <= ST_END;
                            end else begin
                                r_count <= r_count + RW'(1);
                                r_state <= ST_D_LO;
                            end
                        end else begin
                            r_ovalid <= 1'b1;
                            r_odata  <= {rd_b, rd_a, r_aj, r_ai};
                            r_oflags <= '{dropped: r_ovf, capped: r_capped,
                                          found: 1'b1};
                            r_olast  <= (r_count + RW'(1)) == r_total;
                            r_done   <= (r_count + RW'(1)) == r_total;
                            r_count  <= r_count + RW'(1);
                            r_state  <= ST_OUT_WAIT;
                        end
                    end
                end
                ST_D_LO: begin
                    r_state <= (r_lo < r_hi) ? ST_D_LO_CHK : ST_D_HI;
                end
                ST_D_LO_CHK: begin
                    if (rd_a == r_q2) begin
                        r_lo    <= r_lo + CW'(1);
                        r_state <= ST_D_LO;
                    end else begin
                        r_state <= ST_D_HI;
                    end
                end
                ST_D_HI: begin
                    r_state <= (r_lo < r_hi) ? ST_D_HI_CHK : ST_P_TOP;
                end
                ST_D_HI_CHK: begin
                    if (rd_b == r_q3) begin
                        r_hi    <= r_hi - CW'(1);
                        r_state <= ST_D_HI;
                    end else begin
                        r_state <= ST_P_TOP;
                    end
                end
                // duplicate skip at the second and first level
                ST_J_SKIP: begin
                    if (j_next < r_cnt) begin
                        r_state <= ST_J_SKIP_CHK;
                    end else begin
                        r_j     <= j_next;
                        r_state <= ST_J_TOP;
                    end
                end
                ST_J_SKIP_CHK: begin
                    r_j     <= j_next;
                    r_state <= (rd_a == r_aj) ? ST_J_SKIP : ST_J_TOP;
                end
                ST_I_SKIP: begin
                    if (i_next < r_cnt) begin
                        r_state <= ST_I_SKIP_CHK;
                    end else begin
                        r_i     <= i_next;
                        r_state <= ST_I_TOP;
                    end
                end
                ST_I_SKIP_CHK: begin
                    r_i     <= i_next;
                    r_state <= (rd_a == r_ai) ? ST_I_SKIP : ST_I_TOP;
                end
                ST_END: begin
                    if (r_pass2 || r_count == '0) begin
                        // empty answer
                        r_ovalid <= 1'b1;
                        r_odata  <= '0;
                        r_oflags <= '{dropped: r_ovf, capped: 1'b0, found: 1'b0};
                        r_olast  <= 1'b1;
                        r_done   <= 1'b1;
                        r_state  <= ST_OUT_WAIT;
                    end else begin
                        r_total <= r_count;
                        r_pass2 <= 1'b1;
                        r_state <= ST_INIT;
                    end
                end
                ST_OUT_WAIT: begin
                    if (!r_ovalid) begin
                        if (r_done) begin
                            r_done   <= 1'b0;
                            r_pass2  <= 1'b0;
                            r_capped <= 1'b0;
                            r_cnt    <= '0;
                            r_ovf    <= 1'b0;
                            r_state  <= ST_LOAD;
                        end else begin
                            r_state <= ST_D_LO;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oflags;
    assign m_axis_tlast  = r_olast;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_TARGET) ? 32'(r_target) : 32'd0;

`ifndef SYNTH
    // a result never waits while new items are being taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input open while result pending");

    // an empty answer is always the final result
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty result without tlast");

    // emission pass never passes the count found in the counting pass
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass2 |-> (r_count <= r_total))
        else $error("emitted more results than counted");

    // counter never exceeds the result limit
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_MAX)
        else $error("result counter past limit");
`endif

endmodule
